[hdl/uetu_pkg.sv]
package uetu_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] LIM_1B  = 8'h7F;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_HEX0 = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5,
        PH_SKIP = 3'd6
    } t_phase;

    // One command holds all result beats caused by one input beat.
    typedef struct packed {
        logic [1:0]      cnt_m1;
        logic [2:0][7:0] bytes;
        logic            last;
        logic            err;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[hdl/uetu_front.sv]
module uetu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_cmd_valid,
    output uetu_pkg::t_cmd    o_cmd
);

    uetu_pkg::t_phase r_phase, n_phase;
    logic [11:0]      r_acc, n_acc;
    uetu_pkg::t_hex   hex;
    logic [15:0]      cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uetu_pkg::PH_IDLE;
            r_acc   <= 12'd0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    always_comb begin
        hex         = uetu_pkg::hex_decode(i_byte);
        cp          = {r_acc, hex.val};
        n_phase     = r_phase;
        n_acc       = r_acc;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        case (r_phase)
            uetu_pkg::PH_BSL: begin
                if (i_byte == uetu_pkg::CH_U) begin
                    n_acc = 12'd0;
                    if (i_last) begin
                        n_phase     = uetu_pkg::PH_IDLE;
                        o_cmd_valid = 1'b1;
                        o_cmd.last  = 1'b1;
                        o_cmd.err   = 1'b1;
                    end else begin
                        n_phase = uetu_pkg::PH_HEX0;
                    end
                end else begin
                    o_cmd_valid    = 1'b1;
                    o_cmd.bytes[0] = uetu_pkg::CH_BSL;
                    if (i_byte == uetu_pkg::CH_BSL && !i_last) begin
                        n_phase = uetu_pkg::PH_BSL;
                    end else begin
                        n_phase        = uetu_pkg::PH_IDLE;
                        o_cmd.cnt_m1   = 2'd1;
                        o_cmd.bytes[1] = i_byte;
                        o_cmd.last     = i_last;
                    end
                end
            end
            uetu_pkg::PH_HEX0, uetu_pkg::PH_HEX1, uetu_pkg::PH_HEX2, uetu_pkg::PH_HEX3: begin
                if (!hex.ok || (i_last && r_phase != uetu_pkg::PH_HEX3)) begin
                    n_phase     = i_last ? uetu_pkg::PH_IDLE : uetu_pkg::PH_SKIP;
                    n_acc       = 12'd0;
                    o_cmd_valid = 1'b1;
                    o_cmd.last  = 1'b1;
                    o_cmd.err   = 1'b1;
                end else if (r_phase != uetu_pkg::PH_HEX3) begin
                    n_acc   = cp[11:0];
                    n_phase = uetu_pkg::t_phase'(r_phase + 3'd1);
                end else begin
                    n_acc       = 12'd0;
                    n_phase     = uetu_pkg::PH_IDLE;
                    o_cmd_valid = 1'b1;
                    o_cmd.last  = i_last;
                    if (cp[15:7] == 9'd0) begin
                        o_cmd.bytes[0] = cp[7:0];
                    end else if (cp[15:11] == 5'd0) begin
                        o_cmd.cnt_m1   = 2'd1;
                        o_cmd.bytes[0] = {3'b110, cp[10:6]};
                        o_cmd.bytes[1] = {2'b10, cp[5:0]};
                    end else begin
                        o_cmd.cnt_m1   = 2'd2;
                        o_cmd.bytes[0] = {4'b1110, cp[15:12]};
                        o_cmd.bytes[1] = {2'b10, cp[11:6]};
                        o_cmd.bytes[2] = {2'b10, cp[5:0]};
                    end
                end
            end
            uetu_pkg::PH_SKIP: begin
                if (i_last) begin
                    n_phase = uetu_pkg::PH_IDLE;
                    n_acc   = 12'd0;
                end
            end
            default: begin
                n_acc = 12'd0;
                if (i_byte == uetu_pkg::CH_BSL && !i_last) begin
                    n_phase = uetu_pkg::PH_BSL;
                end else begin
                    n_phase        = uetu_pkg::PH_IDLE;
                    o_cmd_valid    = 1'b1;
                    o_cmd.bytes[0] = i_byte;
                    o_cmd.last     = i_last;
                end
            end
        endcase
    end

endmodule

[hdl/uetu_fifo.sv]
module uetu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  uetu_pkg::t_cmd i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output uetu_pkg::t_cmd o_rdata,
    output logic           o_empty
);

    uetu_pkg::t_cmd                 r_mem [uetu_pkg::FIFO_DEPTH];
    logic [uetu_pkg::FIFO_AW-1:0]   r_wptr, r_rptr;
    logic [uetu_pkg::FIFO_AW:0]     r_count;
    logic                           wr_en, rd_en;

    assign o_full  = (r_count == (uetu_pkg::FIFO_AW+1)'(uetu_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/uetu_back.sv]
module uetu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_empty,
    input  uetu_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic           o_error
);

    logic       r_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_byte;
    logic       r_last, r_error;
    logic       load, at_end;

    assign load      = !i_cmd_empty && (!r_valid || i_pop);
    assign at_end    = (r_idx == i_cmd.cnt_m1);
    assign o_cmd_pop = load && at_end;
    assign n_idx     = at_end ? 2'd0 : r_idx + 2'd1;

    assign o_empty = !r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_error = r_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= i_cmd.bytes[r_idx];
            r_last  <= at_end && i_cmd.last;
            r_error <= i_cmd.err;
        end
    end

endmodule

[hdl/unicode_escape_to_utf8.sv]
// Streaming decoder of JSON "\uXXXX" escapes into UTF-8.
// Input side is a queue: drive i_in_byte and i_in_last with push high; the
// beat is taken at a rising edge where full is low. Mark the stream's final
// byte with i_in_last.
// Result side is a queue: while empty is low the oldest result is on
// o_out_byte, o_out_last and o_out_error; it is taken at an edge where pop
// is high. o_out_error beats carry byte zero and end the stream.
// One input beat causes zero to three result beats. A result passes the
// command queue and then the back end's output register before it shows.
// The front decoder takes one byte per cycle while full is low; the back
// end's single output register sends one result per cycle while pop is high;
// so a three-byte code point holds it for three results, and a four-entry
// command queue between them absorbs such bursts before full rises.
// Reset is synchronous: it returns the decoder to plain copy mode and drops
// all queued results. When the receiver stalls, the current result holds
// and the queue fills until full stops the input.
module unicode_escape_to_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_error
);

    logic           in_valid;
    logic           cmd_valid;
    uetu_pkg::t_cmd cmd_in, cmd_out;
    logic           cmd_empty, cmd_pop;

    assign in_valid = push && !full;

    uetu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    uetu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_valid && cmd_valid),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    uetu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_byte      (o_out_byte),
        .o_last      (o_out_last),
        .o_error     (o_out_error)
    );

endmodule

[hdl/uetu_checker.sv]
module uetu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic       o_out_error
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("Queues not cleared by reset.");

    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_error |-> o_out_byte == 8'd0 && o_out_last)
        else $error("Error beat must carry byte zero and end the stream.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_out_last)
            && $stable(o_out_error))
        else $error("Stalled result beat changed.");

endmodule

bind unicode_escape_to_utf8 uetu_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last),
    .o_out_error (o_out_error)
);

[tb/unicode_escape_to_utf8_test.sv]
`timescale 1ns / 1ps

module unicode_escape_to_utf8_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 100;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_utf8_beat;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_error;

    t_utf8_beat        utf8_expected[$];
    uetu_pkg::t_phase  dec_phase = uetu_pkg::PH_IDLE;
    logic [11:0]       dec_acc = 12'h000;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  beats_taken = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;

    unicode_escape_to_utf8 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .o_out_error(o_out_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] v);
        if (v < 4'd10) return 8'("0") + 8'(v);
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    task automatic expect_beat(input logic [7:0] data, input logic last, input logic err);
        t_utf8_beat r;
        r.data = data;
        r.last = last;
        r.err  = err;
        utf8_expected.push_back(r);
    endtask

    task automatic escape_error(input logic last);
        dec_phase = last ? uetu_pkg::PH_IDLE : uetu_pkg::PH_SKIP;
        dec_acc   = 12'h000;
        expect_beat(8'h00, 1'b1, 1'b1);
    endtask

    task automatic copy_plain(input logic [7:0] b, input logic last);
        if (b == uetu_pkg::CH_BSL && !last) begin
            dec_phase = uetu_pkg::PH_BSL;
        end else begin
            dec_phase = uetu_pkg::PH_IDLE;
            expect_beat(b, last, 1'b0);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        int          v;
        logic [15:0] cp;
        v = hex_digit(b);
        case (dec_phase)
            uetu_pkg::PH_BSL: begin
                if (b == uetu_pkg::CH_U) begin
                    if (last) begin
                        escape_error(1'b1);
                    end else begin
                        dec_phase = uetu_pkg::PH_HEX0;
                        dec_acc   = 12'h000;
                    end
                end else begin
                    expect_beat(uetu_pkg::CH_BSL, 1'b0, 1'b0);
                    copy_plain(b, last);
                end
            end
            uetu_pkg::PH_HEX0, uetu_pkg::PH_HEX1, uetu_pkg::PH_HEX2: begin
                if (v < 0 || last) begin
                    escape_error(last);
                end else begin
                    dec_acc   = {dec_acc[7:0], 4'(v)};
                    dec_phase = uetu_pkg::t_phase'(dec_phase + 3'd1);
                end
            end
            uetu_pkg::PH_HEX3: begin
                if (v < 0) begin
                    escape_error(last);
                end else begin
                    cp        = {dec_acc, 4'(v)};
                    dec_acc   = 12'h000;
                    dec_phase = uetu_pkg::PH_IDLE;
                    if (cp <= 16'(uetu_pkg::LIM_1B)) begin
                        expect_beat(cp[7:0], last, 1'b0);
                    end else if (cp <= 16'h07FF) begin
                        expect_beat(8'hC0 | 8'(cp[10:6]), 1'b0, 1'b0);
                        expect_beat(8'h80 | 8'(cp[5:0]), last, 1'b0);
                    end else begin
                        expect_beat(8'hE0 | 8'(cp[15:12]), 1'b0, 1'b0);
                        expect_beat(8'h80 | 8'(cp[11:6]), 1'b0, 1'b0);
                        expect_beat(8'h80 | 8'(cp[5:0]), last, 1'b0);
                    end
                end
            end
            uetu_pkg::PH_SKIP: begin
                if (last) begin
                    dec_phase = uetu_pkg::PH_IDLE;
                    dec_acc   = 12'h000;
                end
            end
            default: begin
                dec_acc = 12'h000;
                copy_plain(b, last);
            end
        endcase
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (full);
        if (dec_phase != uetu_pkg::PH_SKIP) beats_taken++;
        decode_byte(b, last);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (utf8_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_stream();
        logic [7:0]  q[$];
        logic [7:0]  b;
        logic [15:0] cp;
        int          ntok;
        int          kind;
        bit          done;
        ntok = $urandom_range(1, 8);
        done = 0;
        for (int t = 0; t < ntok && !done; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 80) begin
                case ($urandom_range(0, 2))
                    0: cp = 16'($urandom_range(0, 'h7F));
                    1: cp = 16'($urandom_range('h80, 'h7FF));
                    default: cp = 16'($urandom_range('h800, 'hFFFF));
                endcase
                q.push_back(uetu_pkg::CH_BSL);
                q.push_back(uetu_pkg::CH_U);
                for (int d = 3; d >= 0; d--) q.push_back(hex_glyph(cp[d*4 +: 4]));
            end else if (kind < 88) begin
                do b = 8'($urandom_range(0, 255)); while (b == uetu_pkg::CH_U);
                q.push_back(uetu_pkg::CH_BSL);
                q.push_back(b);
            end else if (kind < 94) begin
                q.push_back(uetu_pkg::CH_BSL);
                q.push_back(uetu_pkg::CH_U);
                repeat ($urandom_range(0, 3)) q.push_back(hex_glyph(4'($urandom_range(0, 15))));
                do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
                q.push_back(b);
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
                done = 1;
            end else begin
                q.push_back(uetu_pkg::CH_BSL);
                if ($urandom_range(0, 3) != 0) begin
                    q.push_back(uetu_pkg::CH_U);
                    repeat ($urandom_range(0, 3)) q.push_back(hex_glyph(4'($urandom_range(0, 15))));
                end
                done = 1;
            end
        end
        foreach (q[i]) send_beat(q[i], i == q.size() - 1);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("\\u0041", 1'b0);
        send_text("\\u07fF", 1'b0);
        send_text("\\uFfFf", 1'b1);
        send_text("\\n\\", 1'b1);
        send_text("\\u", 1'b1);
        send_text("\\u1gx", 1'b1);
        send_text("\\u12", 1'b1);
        wait_drained();
    endtask

    task automatic test_random_streams(input int target, input int send_pct, input int recv_pct);
        int start;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = beats_taken;
        while (beats_taken - start < target) send_random_stream();
        wait_drained();
    endtask

    task automatic test_full_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_toggle <= ~hold_toggle;
        send_text("\\uABCD\\u0123", 1'b0);
        for (int i = 0; i < 16; i++) send_beat(8'($urandom_range(0, 255)), i == 15);
        wait_drained();
    endtask

    task automatic test_pause_mid_escape();
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        send_text("ab\\u0", 1'b0);
        wait_drained();
        send_text("9e", 1'b0);
        wait_drained();
        send_text("4z", 1'b1);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Each result beat is checked against the oldest expected one.
    always @(posedge i_clk) begin
        t_utf8_beat exp_beat;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (utf8_expected.size() == 0) begin
                    $display("%0t: unexpected result byte %02h last %b error %b",
                             $time, o_out_byte, o_out_last, o_out_error);
                    mismatch_count++;
                end else begin
                    exp_beat = utf8_expected.pop_front();
                    if (o_out_byte !== exp_beat.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_beat.data, o_out_byte);
                        mismatch_count++;
                    end
                    if (o_out_last !== exp_beat.last) begin
                        $display("%0t: out_last expected %b actual %b",
                                 $time, exp_beat.last, o_out_last);
                        mismatch_count++;
                    end
                    if (o_out_error !== exp_beat.err) begin
                        $display("%0t: out_error expected %b actual %b",
                                 $time, exp_beat.err, o_out_error);
                        mismatch_count++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_streams(100, 0, 0);
        test_full_backpressure();
        test_random_streams(100, 72, 0);
        test_pause_mid_escape();
        test_random_streams(100, 0, 72);
        test_random_streams(100, 36, 36);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && utf8_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
